/* rtl/entropy_bit_extractor_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the entropy bit extractor
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ENTROPY_BIT_EXTRACTOR_UNIT_MACROS_SVH
`define ENTROPY_BIT_EXTRACTOR_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define EBX_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("entropy bit extractor: assertion failed");
`define EBX_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("entropy bit extractor: forbidden condition seen");
`else
`define EBX_ASSERT(lbl, prop)
`define EBX_ASSERT_NEVER(lbl, cond)
`endif

`endif

/* rtl/ebx_pkg.sv */
// ----------------------------------------------------------------------------
// Entropy bit extractor package
// Payload types, register indexes, mode codes and parity constants.
// ----------------------------------------------------------------------------
package ebx_pkg;

  localparam int unsigned CountW = 24;

  // Configuration register indexes.
  localparam logic [7:0] RegExtractMode = 8'd0;
  localparam logic [7:0] RegContinuous  = 8'd1;

  // Extraction modes.
  localparam logic [2:0] ModeA       = 3'd0;
  localparam logic [2:0] ModeB       = 3'd1;
  localparam logic [2:0] ModeXor     = 3'd2;
  localparam logic [2:0] ModeVonNeu  = 3'd3;
  localparam logic [2:0] ModeBoth    = 3'd4;
  localparam logic [2:0] ModeHamming = 3'd5;

  localparam logic [2:0] ModeReset = ModeXor;

  localparam logic [15:0] ParityTable = 16'b0110100110010110;
  localparam logic [3:0]  HamMask0    = 4'b1011;
  localparam logic [3:0]  HamMask1    = 4'b1101;
  localparam logic [3:0]  HamMask2    = 4'b1110;

  typedef struct packed {
    logic              kind;
    logic [1:0]        raw_bits;
    logic [CountW-1:0] req_count;
  } in_item_t;

  typedef struct packed {
    logic [7:0] random_byte;
    logic       request_done;
  } out_item_t;

  typedef struct packed {
    logic [7:0] index;
    logic [7:0] data;
  } cfg_item_t;

  typedef struct packed {
    logic      emit;
    out_item_t item;
  } core_res_t;

  function automatic logic par4(input logic [3:0] v);
    return ParityTable[v];
  endfunction

  function automatic logic [2:0] ham_parity(input logic [3:0] w);
    return {par4(w & HamMask0), par4(w & HamMask1), par4(w & HamMask2)};
  endfunction

endpackage

/* rtl/ebx_chan_if.sv */
// ----------------------------------------------------------------------------
// Entropy bit extractor channel
// Valid/ready channel carrying one payload of a chosen type.
// ----------------------------------------------------------------------------
interface ebx_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/ebx_core.sv */
// ----------------------------------------------------------------------------
// Entropy bit extractor core
// Conditioning state, bit packing and request counting for one item.
// ----------------------------------------------------------------------------
module ebx_core import ebx_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  logic      advance_i,
  input  in_item_t  item_i,
  input  logic [2:0] mode_i,
  input  logic      continuous_i,
  output core_res_t res_o
);

  logic [7:0]        acc_q, acc_d;
  logic [3:0]        total_q, total_d;
  logic [3:0]        win_q, win_d;
  logic              phase_q, phase_d;
  logic [9:0]        store_q, store_d;
  logic [3:0]        ptotal_q, ptotal_d;
  logic [CountW-1:0] rem_q, rem_d;

  always_comb begin
    logic       active;
    logic       a_bit;
    logic       b_bit;
    logic       shift1;
    logic       shift2;
    logic       sbit;
    logic       emit;
    logic [7:0] byte_val;
    logic [3:0] shamt;
    logic [9:0] shifted;

    acc_d    = acc_q;
    total_d  = total_q;
    win_d    = win_q;
    phase_d  = phase_q;
    store_d  = store_q;
    ptotal_d = ptotal_q;
    rem_d    = rem_q;
    emit     = 1'b0;
    byte_val = 8'd0;
    shifted  = 10'd0;
    shamt    = 4'd0;
    shift1   = 1'b0;
    shift2   = 1'b0;
    sbit     = 1'b0;
    a_bit    = item_i.raw_bits[0];
    b_bit    = item_i.raw_bits[1];
    active   = !item_i.kind && ((rem_q != '0) || continuous_i);

    if (item_i.kind) begin
      rem_d = item_i.req_count;
    end else if (active) begin
      case (mode_i)
        ModeA: begin
          shift1 = 1'b1;
          sbit   = a_bit;
        end
        ModeB: begin
          shift1 = 1'b1;
          sbit   = b_bit;
        end
        ModeXor: begin
          shift1 = 1'b1;
          sbit   = a_bit ^ b_bit;
        end
        ModeVonNeu: begin
          // Pairs 00 and 11 carry no bit and leave the accumulator alone.
          shift1 = a_bit ^ b_bit;
          sbit   = b_bit;
        end
        ModeBoth: begin
          shift2 = 1'b1;
        end
        ModeHamming: begin
          win_d   = {win_q[1:0], item_i.raw_bits};
          phase_d = !phase_q;
          if (!phase_q) begin
            store_d  = {store_q[6:0], ham_parity(win_d)};
            ptotal_d = ptotal_q + 4'd3;
          end
        end
        default: begin
        end
      endcase

      if (shift1) begin
        acc_d   = {acc_q[6:0], sbit};
        total_d = total_q + 4'd1;
      end else if (shift2) begin
        acc_d   = {acc_q[5:0], item_i.raw_bits};
        total_d = total_q + 4'd2;
      end

      if (mode_i == ModeHamming) begin
        if (ptotal_d >= 4'd8) begin
          shamt    = ptotal_d - 4'd8;
          shifted  = store_d >> shamt;
          byte_val = shifted[7:0];
          ptotal_d = ptotal_d - 4'd8;
          emit     = 1'b1;
        end
      end else if (mode_i <= ModeBoth) begin
        if (total_d >= 4'd8) begin
          byte_val = acc_d;
          total_d  = total_d - 4'd8;
          emit     = 1'b1;
        end
      end
    end

    res_o.emit                   = valid_i && emit;
    res_o.item.random_byte       = byte_val;
    res_o.item.request_done      = emit && (rem_q == CountW'(1));
    if (emit && (rem_q != '0)) begin
      rem_d = rem_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      total_q  <= '0;
      win_q    <= '0;
      phase_q  <= 1'b0;
      store_q  <= '0;
      ptotal_q <= '0;
      rem_q    <= '0;
    end else if (advance_i) begin
      acc_q    <= acc_d;
      total_q  <= total_d;
      win_q    <= win_d;
      phase_q  <= phase_d;
      store_q  <= store_d;
      ptotal_q <= ptotal_d;
      rem_q    <= rem_d;
    end
  end

endmodule

/* rtl/entropy_bit_extractor_unit.sv */
// ----------------------------------------------------------------------------
// Entropy bit extractor unit
// Conditions raw two-source entropy samples and packs them into bytes.
// ----------------------------------------------------------------------------
// Usage: raw samples and byte requests enter on in_if; kind selects between
// them. Conditioned bytes leave on out_if together with a flag that marks the
// byte which used up the outstanding request. cfg_if writes the extraction
// mode (index 0) and the continuous flag (index 1); it is always ready and
// should only be written while no transaction is in flight.
// Path: an accepted item is held in the input register and its byte, if any,
// is then registered in the output register, from which it leaves on out_if.
// Throughput is one item per cycle while out_if is not stalled: the conditioning
// state is updated as each item advances, so consecutive items need not wait.
// Items that produce no byte (requests, dropped or discarded samples) still
// take one slot in the input register.
// Reset clears the packing state, the request counter and both registers;
// the mode returns to A xor B and continuous mode to off.
// When the receiver stalls, the output register holds its byte and the input
// register holds its item; in_if stays ready until both are occupied.
// ----------------------------------------------------------------------------
`include "entropy_bit_extractor_unit_macros.svh"

module entropy_bit_extractor_unit import ebx_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  ebx_chan_if.sink   in_if,
  ebx_chan_if.source out_if,
  ebx_chan_if.sink   cfg_if
);

  logic       stage_vld_q;
  in_item_t   stage_q;
  logic       out_vld_q;
  out_item_t  out_q;
  logic [2:0] mode_q;
  logic       cont_q;
  logic       stage_adv;
  core_res_t  res;
  cfg_item_t  cfg_w;

  // The input register moves on when the output register is free or drains.
  assign stage_adv   = stage_vld_q && (!out_vld_q || out_if.ready);
  assign in_if.ready = !stage_vld_q || stage_adv;
  assign cfg_if.ready = 1'b1;
  assign cfg_w       = cfg_if.data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeReset;
      cont_q <= 1'b0;
    end else if (cfg_if.valid) begin
      if (cfg_w.index == RegExtractMode) begin
        mode_q <= cfg_w.data[2:0];
      end else if (cfg_w.index == RegContinuous) begin
        cont_q <= cfg_w.data[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_vld_q <= 1'b0;
    end else if (in_if.ready) begin
      stage_vld_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      stage_q <= in_if.data;
    end
  end

  ebx_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (stage_vld_q),
    .advance_i    (stage_adv),
    .item_i       (stage_q),
    .mode_i       (mode_q),
    .continuous_i (cont_q),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (stage_adv && res.emit) begin
      out_vld_q <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_adv && res.emit) begin
      out_q <= res.item;
    end
  end

  assign out_if.valid = out_vld_q;
  assign out_if.data  = out_q;

  `EBX_ASSERT(a_emit_lands, stage_adv && res.emit |=> out_vld_q)
  `EBX_ASSERT(a_ready_low_full, !in_if.ready |-> stage_vld_q && out_vld_q && !out_if.ready)
  `EBX_ASSERT_NEVER(a_request_no_byte, stage_vld_q && stage_q.kind && res.emit)
  `EBX_ASSERT_NEVER(a_emit_without_item, res.emit && !stage_vld_q)

endmodule
